// ----- sv/timing_wheel_wakeup_unit_defines.svh -----
// Assertion macros shared by the timing wheel RTL.
`ifndef TIMING_WHEEL_WAKEUP_UNIT_DEFINES_SVH
`define TIMING_WHEEL_WAKEUP_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define TWHEEL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence follows an antecedent in the same cycle.
`define TWHEEL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/twheel_pkg.sv -----
package twheel_pkg;

    localparam int TIME_W           = 64;
    localparam int HANDLE_W         = 16;
    localparam int PREC_W           = 32;
    localparam int NUM_BUCKETS_DEF  = 64;
    localparam int SLOTS_DEF        = 16;
    localparam int MAX_RESULTS      = 16;

    localparam logic [PREC_W-1:0] PREC_RESET = 32'd1000000;

    // item kinds
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    // release status codes
    localparam logic [1:0] STAT_DUE    = 2'd0;
    localparam logic [1:0] STAT_EARLY  = 2'd1;
    localparam logic [1:0] STAT_FORCED = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [1:0]          status;
    } rel_t;

endpackage

// ----- sv/twheel_div.sv -----
module twheel_div #(
    parameter int NUM_BUCKETS = twheel_pkg::NUM_BUCKETS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [twheel_pkg::TIME_W-1:0]    dividend,
    input  logic [twheel_pkg::PREC_W-1:0]    divisor,
    output logic                             done,
    output logic [$clog2(NUM_BUCKETS)-1:0]   bucket
);
    import twheel_pkg::*;

    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int CNT_W = $clog2(TIME_W + 1);
    localparam logic [BW:0] NB_W = (BW+1)'(NUM_BUCKETS);

    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] dvd_reg;
    logic [PREC_W-1:0] rem_reg;
    logic [BW-1:0]     qmod_reg;
    logic              done_reg;

    logic [PREC_W:0]   rem_sh;
    logic              ge;
    logic [PREC_W:0]   rem_sub;
    logic [BW:0]       qm2;
    logic [BW-1:0]     qmod_next;
    logic [BW:0]       qinc;

    // one quotient bit per cycle, quotient kept modulo the bucket count
    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[TIME_W-1]};
        ge        = rem_sh >= {1'b0, divisor};
        rem_sub   = rem_sh - {1'b0, divisor};
        qm2       = {qmod_reg, ge};
        qmod_next = (qm2 >= NB_W) ? BW'(qm2 - NB_W) : qm2[BW-1:0];
        qinc      = {1'b0, qmod_reg} + (BW+1)'(1);
        bucket    = (qinc == NB_W) ? '0 : qinc[BW-1:0];
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(TIME_W);
                dvd_reg  <= dividend;
                rem_reg  <= '0;
                qmod_reg <= '0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                dvd_reg  <= {dvd_reg[TIME_W-2:0], 1'b0};
                rem_reg  <= ge ? rem_sub[PREC_W-1:0] : rem_sh[PREC_W-1:0];
                qmod_reg <= qmod_next;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end
endmodule

// ----- sv/twheel_bucket_mem.sv -----
module twheel_bucket_mem #(
    parameter int NUM_BUCKETS      = twheel_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = twheel_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [$clog2(NUM_BUCKETS)-1:0]   rd_addr,
    output logic [twheel_pkg::TIME_W-1:0]    rd_scan,
    output logic [SLOTS_PER_BUCKET-1:0]      rd_mask,
    input  logic                             wr_en,
    input  logic [$clog2(NUM_BUCKETS)-1:0]   wr_addr,
    input  logic [twheel_pkg::TIME_W-1:0]    wr_scan,
    input  logic [SLOTS_PER_BUCKET-1:0]      wr_mask
);
    import twheel_pkg::*;

    logic [TIME_W-1:0]           scan_mem [NUM_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0] mask_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0]      row_valid_reg;
    logic                        hit_reg;
    logic [TIME_W-1:0]           scan_reg;
    logic [SLOTS_PER_BUCKET-1:0] mask_reg;

    // track written rows; an unwritten row reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                hit_reg <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            scan_mem[wr_addr] <= wr_scan;
            mask_mem[wr_addr] <= wr_mask;
        end
        if (rd_en)
        begin
            scan_reg <= scan_mem[rd_addr];
            mask_reg <= mask_mem[rd_addr];
        end
    end

    assign rd_scan = hit_reg ? scan_reg : '0;
    assign rd_mask = hit_reg ? mask_reg : '0;
endmodule

// ----- sv/twheel_slot_mem.sv -----
module twheel_slot_mem #(
    parameter int DEPTH = twheel_pkg::NUM_BUCKETS_DEF * twheel_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic [twheel_pkg::TIME_W-1:0]   wr_wake,
    input  logic [twheel_pkg::HANDLE_W-1:0] wr_handle,
    input  logic                            rd_en,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic [twheel_pkg::TIME_W-1:0]   rd_wake,
    output logic [twheel_pkg::HANDLE_W-1:0] rd_handle
);
    import twheel_pkg::*;

    logic [TIME_W-1:0]   wake_mem   [DEPTH];
    logic [HANDLE_W-1:0] handle_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wake_mem[wr_addr]   <= wr_wake;
            handle_mem[wr_addr] <= wr_handle;
        end
        if (rd_en)
        begin
            rd_wake   <= wake_mem[rd_addr];
            rd_handle <= handle_mem[rd_addr];
        end
    end
endmodule

// ----- sv/timing_wheel_wakeup_unit.sv -----
// Timing wheel wakeup unit: a single-level hashed wheel of sleeping tasks.
// Input channel (in_valid/in_stall) takes one item at a time: kind selects
// register task, tick (scan next bucket) or drain (force-empty drain_bucket).
// Output channel (out_valid/out_stall) hands back released task handles with
// a status; last_of_run marks the final result of one input item.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes tick_precision;
// write it only while the block is idle.
// A register item runs a restoring divide to find its bucket, then reads the
// bucket row and writes a free slot, or reports the task early or full. A
// tick or drain reads the bucket row, then scans its slots, skipping each
// empty slot and reading then checking each occupied one, and flushes the
// held result at the end. in_stall stays high until the item is fully done.
// Each released handle is held one step back so the final one is tagged;
// when the receiver stalls the scan waits on the output register.
// Reset clears the wheel start, bucket index, scan stamps and occupancy
// at once; no clearing pass is needed.
module timing_wheel_wakeup_unit #(
    parameter int NUM_BUCKETS      = twheel_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = twheel_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [twheel_pkg::HANDLE_W-1:0] task_handle,
    input  logic [twheel_pkg::TIME_W-1:0]   wake_time,
    input  logic [twheel_pkg::TIME_W-1:0]   now_time,
    input  logic [5:0]                      drain_bucket,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [twheel_pkg::HANDLE_W-1:0] released_handle,
    output logic [1:0]                      release_status,
    output logic                            last_of_run,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [twheel_pkg::PREC_W-1:0]   cfg_data
);
    import twheel_pkg::*;
    `include "timing_wheel_wakeup_unit_defines.svh"

    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int SIW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SCW   = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW    = $clog2(DEPTH);
    localparam int NCW   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_REG_RD, ST_REG_CHK,
        ST_REL_RD, ST_REL_MASK, ST_SCAN_RD, ST_SCAN_CHK, ST_FLUSH
    } state_t;

    state_t                      state_reg;
    logic [PREC_W-1:0]           prec_reg;
    logic [TIME_W-1:0]           start_reg;
    logic [BW-1:0]               cur_reg;
    logic [BW-1:0]               bkt_reg;
    logic                        force_reg;
    logic [HANDLE_W-1:0]         handle_reg;
    logic [TIME_W-1:0]           wake_reg;
    logic [TIME_W-1:0]           now_reg;
    logic [SLOTS_PER_BUCKET-1:0] mask_reg;
    logic [SCW-1:0]              sc_reg;
    logic [NCW-1:0]              n_reg;
    logic                        pend_valid_reg;
    rel_t                        pend_reg;
    logic                        out_valid_reg;
    rel_t                        out_reg;
    logic                        out_last_reg;

    logic                        in_accept;
    logic                        out_free;
    logic [BW-1:0]               cur_inc;
    logic                        div_start;
    logic                        div_done;
    logic [BW-1:0]               div_bucket;
    logic [PREC_W-1:0]           prec_eff;
    logic                        bm_rd_en;
    logic [TIME_W-1:0]           bm_rd_scan;
    logic [SLOTS_PER_BUCKET-1:0] bm_rd_mask;
    logic                        bm_wr_en;
    logic [TIME_W-1:0]           bm_wr_scan;
    logic [SLOTS_PER_BUCKET-1:0] bm_wr_mask;
    logic                        sm_wr_en;
    logic                        sm_rd_en;
    logic [TIME_W-1:0]           sm_rd_wake;
    logic [HANDLE_W-1:0]         sm_rd_handle;
    logic [AW-1:0]               slot_base;
    logic [AW-1:0]               slot_addr;
    logic [SIW-1:0]              free_idx;
    logic                        free_any;
    logic [SIW-1:0]              sc_idx;
    logic                        scan_end;
    logic                        slot_hit;
    logic                        out_push;
    rel_t                        push_data;
    logic                        push_last;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign prec_eff  = (prec_reg == '0) ? PREC_W'(1) : prec_reg;
    assign cur_inc   = (cur_reg == BW'(NUM_BUCKETS - 1)) ? '0 : cur_reg + BW'(1);
    assign sc_idx    = sc_reg[SIW-1:0];
    assign scan_end  = (sc_reg == SCW'(SLOTS_PER_BUCKET)) || (n_reg == NCW'(MAX_RESULTS));
    assign slot_hit  = force_reg || (sm_rd_wake <= now_reg);
    assign slot_base = AW'(bkt_reg) * AW'(SLOTS_PER_BUCKET);

    // lowest free slot of the bucket row
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--)
        begin
            if (!bm_rd_mask[i])
            begin
                free_idx = SIW'(i);
                free_any = 1'b1;
            end
        end
    end

    // memory controls
    always_comb
    begin
        div_start  = in_accept && (kind == KIND_REG) && (wake_time > start_reg);
        bm_rd_en   = (state_reg == ST_REG_RD) || (state_reg == ST_REL_RD);
        bm_wr_en   = 1'b0;
        bm_wr_scan = now_reg;
        bm_wr_mask = mask_reg;
        sm_wr_en   = 1'b0;
        sm_rd_en   = (state_reg == ST_SCAN_RD) && !scan_end && mask_reg[sc_idx];
        slot_addr  = slot_base + AW'(sc_idx);
        if (state_reg == ST_REG_CHK)
        begin
            slot_addr = slot_base + AW'(free_idx);
            if ((bm_rd_scan < wake_reg) && free_any)
            begin
                bm_wr_en   = 1'b1;
                sm_wr_en   = 1'b1;
                bm_wr_scan = bm_rd_scan;
                bm_wr_mask = bm_rd_mask | (SLOTS_PER_BUCKET'(1) << free_idx);
            end
        end
        else if ((state_reg == ST_SCAN_RD) && scan_end)
        begin
            bm_wr_en = 1'b1;
        end
    end

    // push to the output register
    always_comb
    begin
        out_push  = 1'b0;
        push_data = pend_reg;
        push_last = 1'b0;
        if ((state_reg == ST_SCAN_CHK) && slot_hit && pend_valid_reg && out_free)
            out_push = 1'b1;
        else if ((state_reg == ST_FLUSH) && pend_valid_reg && out_free)
        begin
            out_push  = 1'b1;
            push_last = 1'b1;
        end
    end

    twheel_div #(.NUM_BUCKETS(NUM_BUCKETS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wake_time - start_reg - TIME_W'(1)),
        .divisor  (prec_eff),
        .done     (div_done),
        .bucket   (div_bucket)
    );

    twheel_bucket_mem #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_bucket_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (bm_rd_en),
        .rd_addr (bkt_reg),
        .rd_scan (bm_rd_scan),
        .rd_mask (bm_rd_mask),
        .wr_en   (bm_wr_en),
        .wr_addr (bkt_reg),
        .wr_scan (bm_wr_scan),
        .wr_mask (bm_wr_mask)
    );

    twheel_slot_mem #(.DEPTH(DEPTH)) u_slot_mem (
        .clk       (clk),
        .wr_en     (sm_wr_en),
        .wr_addr   (slot_addr),
        .wr_wake   (wake_reg),
        .wr_handle (handle_reg),
        .rd_en     (sm_rd_en),
        .rd_addr   (slot_addr),
        .rd_wake   (sm_rd_wake),
        .rd_handle (sm_rd_handle)
    );

    // sequencer, wheel registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prec_reg       <= PREC_RESET;
            start_reg      <= '0;
            cur_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            sc_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                prec_reg <= cfg_data;

            if (out_push)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= push_data;
                out_last_reg  <= push_last;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        handle_reg <= task_handle;
                        wake_reg   <= wake_time;
                        now_reg    <= now_time;
                        n_reg      <= '0;
                        case (kind)
                            KIND_REG:
                            begin
                                if (wake_time <= start_reg)
                                begin
                                    pend_reg       <= '{handle: task_handle, status: STAT_EARLY};
                                    pend_valid_reg <= 1'b1;
                                    state_reg      <= ST_FLUSH;
                                end
                                else
                                    state_reg <= ST_DIV;
                            end
                            KIND_TICK:
                            begin
                                cur_reg   <= cur_inc;
                                bkt_reg   <= cur_inc;
                                force_reg <= 1'b0;
                                if (cur_inc == '0)
                                    start_reg <= now_time;
                                state_reg <= ST_REL_RD;
                            end
                            KIND_DRAIN:
                            begin
                                if (32'(drain_bucket) < 32'(NUM_BUCKETS))
                                begin
                                    bkt_reg   <= BW'(drain_bucket);
                                    force_reg <= 1'b1;
                                    state_reg <= ST_REL_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        bkt_reg   <= div_bucket;
                        state_reg <= ST_REG_RD;
                    end
                end
                ST_REG_RD:
                begin
                    state_reg <= ST_REG_CHK;
                end
                ST_REG_CHK:
                begin
                    if (bm_rd_scan >= wake_reg)
                    begin
                        pend_reg       <= '{handle: handle_reg, status: STAT_EARLY};
                        pend_valid_reg <= 1'b1;
                        state_reg      <= ST_FLUSH;
                    end
                    else if (!free_any)
                    begin
                        pend_reg       <= '{handle: handle_reg, status: STAT_FULL};
                        pend_valid_reg <= 1'b1;
                        state_reg      <= ST_FLUSH;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_REL_RD:
                begin
                    state_reg <= ST_REL_MASK;
                end
                ST_REL_MASK:
                begin
                    mask_reg  <= bm_rd_mask;
                    sc_reg    <= '0;
                    state_reg <= ST_SCAN_RD;
                end
                ST_SCAN_RD:
                begin
                    if (scan_end)
                        state_reg <= ST_FLUSH;
                    else if (mask_reg[sc_idx])
                        state_reg <= ST_SCAN_CHK;
                    else
                        sc_reg <= sc_reg + SCW'(1);
                end
                ST_SCAN_CHK:
                begin
                    if (!slot_hit)
                    begin
                        sc_reg    <= sc_reg + SCW'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        pend_reg.handle   <= sm_rd_handle;
                        pend_reg.status   <= force_reg ? STAT_FORCED : STAT_DUE;
                        pend_valid_reg    <= 1'b1;
                        mask_reg[sc_idx]  <= 1'b0;
                        n_reg             <= n_reg + NCW'(1);
                        sc_reg            <= sc_reg + SCW'(1);
                        state_reg         <= ST_SCAN_RD;
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                        state_reg <= ST_IDLE;
                    else if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign released_handle = out_reg.handle;
    assign release_status  = out_reg.status;
    assign last_of_run     = out_last_reg;

    `TWHEEL_ASSERT_ALWAYS(a_result_limit, n_reg <= NCW'(MAX_RESULTS), "too many results for one item")
    `TWHEEL_ASSERT_IMPL(a_push_free, out_push, out_free, "output overwritten while stalled")
    `TWHEEL_ASSERT_IMPL(a_idle_no_pend, state_reg == ST_IDLE, !pend_valid_reg, "pending result left at idle")
    `TWHEEL_ASSERT_IMPL(a_slot_rd_occupied, sm_rd_en, mask_reg[sc_idx] && !scan_end, "read of free slot")
endmodule
